// ===== design/rrst_pkg.sv =====
// Package for the reliable receive sequence tracker.
// Holds the sequence id type, fixed constants, the controller state type and the
// chain control struct. Depends on nothing.
package rrst_pkg;

    // Width of a sequence id; ids wrap at 65536.
    localparam int SEQ_W = 16;

    typedef logic [SEQ_W-1:0] seq_id_t;

    // Cumulative received id loaded at reset, one below the first expected id.
    localparam seq_id_t RESET_UP_TO = 16'd99;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } rrst_state_t;

    // Control for the row of cells in one cycle.
    typedef struct packed {
        logic shift;   // every cell but the last takes its upper neighbour's value, head drops out
        logic append;  // the cell at the write position takes the write data
    } chain_ctl_t;

endpackage

// ===== design/rrst_req_if.sv =====
// Request channel of the sequence tracker: valid, ready and the sequence id.
// Depends on rrst_pkg.
interface rrst_req_if;

    logic              valid;
    logic              ready;
    rrst_pkg::seq_id_t sequence_id;

    modport source (output valid, output sequence_id, input ready);
    modport sink   (input valid, input sequence_id, output ready);

endinterface

// ===== design/rrst_rsp_if.sv =====
// Result channel of the sequence tracker: valid, ready and the receipt fields.
// Depends on rrst_pkg.
interface rrst_rsp_if;

    logic              valid;
    logic              ready;
    logic              deliver;
    logic              duplicate;
    logic              overflow;
    rrst_pkg::seq_id_t receipt_id;
    rrst_pkg::seq_id_t next_expected_id;
    logic              pending_nonempty;

    modport source (
        output valid, output deliver, output duplicate, output overflow,
        output receipt_id, output next_expected_id, output pending_nonempty,
        input ready
    );
    modport sink (
        input valid, input deliver, input duplicate, input overflow,
        input receipt_id, input next_expected_id, input pending_nonempty,
        output ready
    );

endinterface

// ===== design/rrst_cell.sv =====
// One cell of the pending id row: holds a single stored sequence id.
// Depends on rrst_pkg.
module rrst_cell (
    input  logic                 clk,
    input  rrst_pkg::chain_ctl_t ctl,
    input  logic                 wr_sel,
    input  rrst_pkg::seq_id_t    wr_data,
    input  rrst_pkg::seq_id_t    from_next,
    output rrst_pkg::seq_id_t    value
);
    import rrst_pkg::*;

    seq_id_t value_reg;
    seq_id_t value_next;

    // A write at this position wins over the shift from the neighbour.
    always_comb
    begin
        value_next = value_reg;
        if (ctl.append && wr_sel)
        begin
            value_next = wr_data;
        end
        else if (ctl.shift)
        begin
            value_next = from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== design/rrst_chain.sv =====
// Row of pending id cells; cell 0 is the head that the controller inspects.
// Depends on rrst_pkg and rrst_cell.
module rrst_chain #(
    parameter int DEPTH = 32
) (
    input  logic                            clk,
    input  rrst_pkg::chain_ctl_t            ctl,
    input  logic [$clog2(DEPTH+1)-1:0]      wr_pos,
    input  rrst_pkg::seq_id_t               wr_data,
    output rrst_pkg::seq_id_t               head
);
    import rrst_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    seq_id_t cell_value [DEPTH];

    // Each cell takes from its upper neighbour; the last one reloads itself.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        seq_id_t from_next;
        logic    wr_sel;

        if (i < DEPTH - 1)
        begin : g_mid
            assign from_next = cell_value[i+1];
        end
        else
        begin : g_last
            assign from_next = cell_value[i];
        end

        assign wr_sel = (wr_pos == CNT_W'(i));

        rrst_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .wr_sel    (wr_sel),
            .wr_data   (wr_data),
            .from_next (from_next),
            .value     (cell_value[i])
        );
    end

    assign head = cell_value[0];

endmodule

// ===== design/reliable_receive_sequence_tracker.sv =====
// Top level of the reliable receive sequence tracker (selective-repeat receive window).
// Depends on rrst_pkg, rrst_req_if, rrst_rsp_if and rrst_chain.
//
//   channel   direction  payload
//   request   in         sequence_id
//   result    out        deliver, duplicate, overflow, receipt_id,
//                        next_expected_id, pending_nonempty
//   cfg       in         cfg_wr_en, cfg_wr_data (initial_received_up_to)
//
// An id outside the window goes from the state that takes the request straight to the
// one that registers the result. Any other id adds one scan pass over the N stored ids
// by rotating the row of cells once (one more step when the id is inserted among
// them), and a drain pass over the N stored ids after the scan when it is the next
// expected id.
// Reset loads the cumulative id with 99 and empties the store.
// A new request is taken while the previous result waits on the output register;
// a result that finds that register still full waits in the last state.
module reliable_receive_sequence_tracker #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  rrst_pkg::seq_id_t cfg_wr_data,
    rrst_req_if.sink          request,
    rrst_rsp_if.source        result
);
    import rrst_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PENDING_DEPTH);
    localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);
    localparam seq_id_t          ONE_ID     = SEQ_W'(1);

    rrst_state_t      state_reg, state_next;
    seq_id_t          id_reg, id_next;
    seq_id_t          rut_reg, rut_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             found_reg, found_next;
    logic             ins_reg, ins_next;
    logic             near_reg, near_next;
    logic             win_reg, win_next;
    logic             full_reg, full_next;

    logic             out_valid_reg;
    logic             out_deliver_reg;
    logic             out_duplicate_reg;
    logic             out_overflow_reg;
    seq_id_t          out_receipt_reg;
    seq_id_t          out_next_exp_reg;
    logic             out_nonempty_reg;
    logic             load_out;

    chain_ctl_t       chain_ctl;
    logic [CNT_W-1:0] wr_pos;
    seq_id_t          wr_data;
    seq_id_t          head;
    seq_id_t          ahead;
    seq_id_t          rut_inc;
    logic             delivered;

    rrst_chain #(
        .DEPTH (PENDING_DEPTH)
    ) u_chain (
        .clk     (clk),
        .ctl     (chain_ctl),
        .wr_pos  (wr_pos),
        .wr_data (wr_data),
        .head    (head)
    );

    // Window distance of the offered id ahead of the cumulative id.
    assign ahead     = request.sequence_id - rut_reg;
    assign rut_inc   = rut_reg + ONE_ID;
    assign delivered = win_reg && !found_reg;

    assign request.ready = (state_reg == ST_IDLE);

    // Next state, chain control and item bookkeeping.
    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        rut_next   = rut_reg;
        occ_next   = occ_reg;
        rem_next   = rem_reg;
        found_next = found_reg;
        ins_next   = ins_reg;
        near_next  = near_reg;
        win_next   = win_reg;
        full_next  = full_reg;
        chain_ctl  = '0;
        wr_pos     = occ_reg - ONE_COUNT;
        wr_data    = head;
        load_out   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    id_next    = request.sequence_id;
                    win_next   = (ahead != '0) && !ahead[SEQ_W-1];
                    near_next  = (ahead == ONE_ID);
                    found_next = 1'b0;
                    ins_next   = 1'b0;
                    full_next  = (occ_reg == FULL_COUNT);
                    rem_next   = occ_reg;
                    state_next = ((ahead != '0) && !ahead[SEQ_W-1]) ? ST_SCAN : ST_DONE;
                end
            end

            ST_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    // End of the pass: place an id larger than all stored ones.
                    if (!near_reg && !found_reg && !full_reg && !ins_reg)
                    begin
                        chain_ctl.append = 1'b1;
                        wr_pos           = occ_reg;
                        wr_data          = id_reg;
                        occ_next         = occ_reg + ONE_COUNT;
                        state_next       = ST_DONE;
                    end
                    else if (near_reg && !found_reg)
                    begin
                        rut_next   = id_reg;
                        rem_next   = occ_reg;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (!near_reg && !found_reg && !full_reg && !ins_reg && (head > id_reg))
                begin
                    // Insert ahead of the first larger id; the head is held while the id is written at the tail.
                    chain_ctl.append = 1'b1;
                    wr_pos           = occ_reg;
                    wr_data          = id_reg;
                    occ_next         = occ_reg + ONE_COUNT;
                    ins_next         = 1'b1;
                end
                else
                begin
                    // Rotate the head to the tail and look for the id.
                    chain_ctl.shift  = 1'b1;
                    chain_ctl.append = 1'b1;
                    rem_next         = rem_reg - ONE_COUNT;
                    if (head == id_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (head == rut_inc)
                begin
                    // The head is the next id: drop it and advance.
                    chain_ctl.shift = 1'b1;
                    rut_next        = rut_inc;
                    occ_next        = occ_reg - ONE_COUNT;
                    rem_next        = rem_reg - ONE_COUNT;
                end
                else
                begin
                    chain_ctl.shift  = 1'b1;
                    chain_ctl.append = 1'b1;
                    rem_next         = rem_reg - ONE_COUNT;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write loads the cumulative id at once.
        if (cfg_wr_en)
        begin
            rut_next = cfg_wr_data;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rut_reg   <= RESET_UP_TO;
            occ_reg   <= '0;
            rem_reg   <= '0;
            found_reg <= 1'b0;
            ins_reg   <= 1'b0;
            near_reg  <= 1'b0;
            win_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rut_reg   <= rut_next;
            occ_reg   <= occ_next;
            rem_reg   <= rem_next;
            found_reg <= found_next;
            ins_reg   <= ins_next;
            near_reg  <= near_next;
            win_reg   <= win_next;
            full_reg  <= full_next;
        end
    end

    // The item id is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_deliver_reg   <= delivered;
            out_duplicate_reg <= !delivered;
            out_overflow_reg  <= delivered && !near_reg && full_reg;
            out_receipt_reg   <= id_reg;
            out_next_exp_reg  <= rut_inc;
            out_nonempty_reg  <= (occ_reg != '0);
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.deliver          = out_deliver_reg;
    assign result.duplicate        = out_duplicate_reg;
    assign result.overflow         = out_overflow_reg;
    assign result.receipt_id       = out_receipt_reg;
    assign result.next_expected_id = out_next_exp_reg;
    assign result.pending_nonempty = out_nonempty_reg;

endmodule

// ===== design/rrst_checker.sv =====
// Port-level checks for the reliable receive sequence tracker, with its bind.
// Depends on rrst_pkg and reliable_receive_sequence_tracker.
module rrst_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              deliver,
    input logic              duplicate,
    input logic              overflow,
    input rrst_pkg::seq_id_t receipt_id,
    input rrst_pkg::seq_id_t next_expected_id,
    input logic              pending_nonempty
);
    import rrst_pkg::*;

    // Every result is either a delivery or a duplicate, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (deliver != duplicate))
    else $error("result is not exactly one of deliver and duplicate");

    // An overflow only happens on a message that is still delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && overflow |-> deliver)
    else $error("overflow raised on a message that was not delivered");

    // One request at a time: after a request is taken the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken twice in consecutive cycles");

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(receipt_id)
            && $stable(next_expected_id) && $stable(pending_nonempty)
            && $stable(deliver))
    else $error("stalled result changed");

endmodule

bind reliable_receive_sequence_tracker rrst_checker u_rrst_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (request.valid),
    .req_ready        (request.ready),
    .rsp_valid        (result.valid),
    .rsp_ready        (result.ready),
    .deliver          (result.deliver),
    .duplicate        (result.duplicate),
    .overflow         (result.overflow),
    .receipt_id       (result.receipt_id),
    .next_expected_id (result.next_expected_id),
    .pending_nonempty (result.pending_nonempty)
);
